@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks in the monitor's RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SDRM_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant check failed");

// Whenever pre holds, post must hold in the same cycle.
`define SDRM_ASSERT_IMPLIES(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("implication check failed");

`endif

@@ rtl/core/sdrm_pkg.sv @@
// ----------------------------------------------------------------------------
// sdrm_pkg
// Types, constants and time helpers shared by the rewind monitor modules.
// ----------------------------------------------------------------------------
package sdrm_pkg;

  localparam int TIME_W     = 32;
  localparam int POS_W      = 24;
  localparam int DIST_W     = 24;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_W       = 168;
  localparam int ENTRY_W    = 3 * POS_W + TIME_W;
  localparam int SQ_W       = 2 * (POS_W + 1);
  localparam int D2_W       = SQ_W + 2;
  localparam int R2_W       = 2 * DIST_W;

  localparam logic [TIME_W-1:0] RST_BLK_LIMIT   = 32'd2000;
  localparam logic [TIME_W-1:0] RST_BLK_REWIND  = 32'd6000;
  localparam logic [DIST_W-1:0] RST_STILL_RAD   = 24'd500;
  localparam logic [TIME_W-1:0] RST_WINDOW      = 32'd10000;
  localparam logic [DIST_W-1:0] RST_STILL_DIST  = 24'd10000;
  localparam logic [TIME_W-1:0] RST_STILL_TIME  = 32'd20000;
  localparam logic [TIME_W-1:0] RST_SAMPLE_GAP  = 32'd200;

  typedef enum logic [CMD_W-1:0] {
    CMD_ODOM     = 3'd0,
    CMD_TRAJ     = 3'd1,
    CMD_POLL     = 3'd2,
    CMD_MANUAL   = 3'd3,
    CMD_CLEAR    = 3'd4,
    CMD_CHECK_EN = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLK_LIMIT  = 3'd0,
    REG_BLK_REWIND = 3'd1,
    REG_STILL_RAD  = 3'd2,
    REG_WINDOW     = 3'd3,
    REG_STILL_DIST = 3'd4,
    REG_STILL_TIME = 3'd5,
    REG_SAMPLE_GAP = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } pos_t;

  typedef struct packed {
    pos_t              pos;
    logic [TIME_W-1:0] t;
  } entry_t;

  typedef struct packed {
    logic valid;
    pos_t p;
    pos_t a;
    pos_t b;
  } dist_req_t;

  typedef struct packed {
    logic            valid;
    logic [D2_W-1:0] da;
    logic [D2_W-1:0] db;
  } dist_rsp_t;

  // Exact signed difference a - b compared against an unsigned limit.
  function automatic logic tdiff_lt(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b,
                                    input logic [TIME_W-1:0] lim);
    logic signed [TIME_W+1:0] d;
    d = $signed({2'b00, a}) - $signed({2'b00, b});
    return d < $signed({2'b00, lim});
  endfunction

  function automatic logic tdiff_gt(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b,
                                    input logic [TIME_W-1:0] lim);
    logic signed [TIME_W+1:0] d;
    d = $signed({2'b00, a}) - $signed({2'b00, b});
    return d > $signed({2'b00, lim});
  endfunction

endpackage

@@ rtl/core/sdrm_ram.sv @@
// ----------------------------------------------------------------------------
// sdrm_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module sdrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/sdrm_dist.sv @@
// ----------------------------------------------------------------------------
// sdrm_dist
// Three-stage pipeline giving squared distances from p to a and from p to b.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdrm_dist (
  input  logic                 clk,
  input  logic                 rst,
  input  sdrm_pkg::dist_req_t  req,
  output sdrm_pkg::dist_rsp_t  rsp
);

  import sdrm_pkg::*;

  logic signed [POS_W-1:0] pc [3];
  logic signed [POS_W-1:0] ac [3];
  logic signed [POS_W-1:0] bc [3];
  logic signed [POS_W:0]   dfa [3];
  logic signed [POS_W:0]   dfb [3];
  logic [SQ_W-1:0]         sqa [3];
  logic [SQ_W-1:0]         sqb [3];
  logic                    v1, v2;

  assign pc[0] = req.p.x;
  assign pc[1] = req.p.y;
  assign pc[2] = req.p.z;
  assign ac[0] = req.a.x;
  assign ac[1] = req.a.y;
  assign ac[2] = req.a.z;
  assign bc[0] = req.b.x;
  assign bc[1] = req.b.y;
  assign bc[2] = req.b.z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      v1        <= req.valid;
      v2        <= v1;
      rsp.valid <= v2;
    end
    for (int i = 0; i < 3; i++) begin
      dfa[i] <= $signed({pc[i][POS_W-1], pc[i]}) - $signed({ac[i][POS_W-1], ac[i]});
      dfb[i] <= $signed({pc[i][POS_W-1], pc[i]}) - $signed({bc[i][POS_W-1], bc[i]});
      // Operands are widened first so the product keeps all of its bits.
      sqa[i] <= SQ_W'($unsigned(SQ_W'(dfa[i]) * SQ_W'(dfa[i])));
      sqb[i] <= SQ_W'($unsigned(SQ_W'(dfb[i]) * SQ_W'(dfb[i])));
    end
    rsp.da <= {2'b00, sqa[0]} + {2'b00, sqa[1]} + {2'b00, sqa[2]};
    rsp.db <= {2'b00, sqb[0]} + {2'b00, sqb[1]} + {2'b00, sqb[2]};
  end

  `SDRM_ASSERT_IMPLIES(a_dist_latency, rsp.valid, $past(req.valid, 3))
  `SDRM_ASSERT_IMPLIES(a_dist_pipe, v2, $past(v1))
  `SDRM_ASSERT_IMPLIES(a_dist_sum_bound, rsp.valid, rsp.da[D2_W-1] == 1'b0)

endmodule

@@ rtl/core/stuck_detect_rewind_monitor_unit.sv @@
// Clear, trajectory, manual rewind, enable, unused codes, a sample inside the minimum gap
// and a poll that decides at once go straight to the result. A stored sample reads and
// checks each expired tail sample in turn before it is written; a distance-limited rewind
// poll waits for the distance pipeline. A stationary scan makes one history read per cycle.
// One word at a time.
// Reset is synchronous and clears control state; history memory is not cleared.
// ----------------------------------------------------------------------------
// stuck_detect_rewind_monitor_unit
// Stuck detection and rewind control over a timestamped position history.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stuck_detect_rewind_monitor_unit #(
  parameter int HISTORY_DEPTH = 64,
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1),
  localparam int OUT_W = ((3 + CNT_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // time_ms[31:0], pos_x[55:32], pos_y[79:56], pos_z[103:80], flag[104],
  // req_duration_ms[136:105], req_distance_mm[160:137], zero pad
  input  logic [sdrm_pkg::IN_W-1:0]        s_axis_tdata,
  // command[2:0]
  input  logic [sdrm_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // rewind_active[0], rewind_started[1], blocked_timing[2], history_count, zero pad
  output logic [OUT_W-1:0]                 m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [sdrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdrm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import sdrm_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0]  LAST_PTR = AW'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W:0] DEPTH_X  = (CNT_W + 1)'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] FULL_M1 = CNT_W'(HISTORY_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_ODO_ISS, ST_ODO_CMP, ST_ODO_FIX, ST_ODO_WR,
    ST_PA_WAIT, ST_PS_OLD, ST_PS_OLDW, ST_PS_CHK, ST_PS_RUN, ST_FIN
  } state_t;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == LAST_PTR) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == '0) r = LAST_PTR;
    else r = p - 1'b1;
    return r;
  endfunction

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [CNT_W-1:0] k);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(p) + (CNT_W + 1)'(k);
    if (s >= DEPTH_X) s = s - DEPTH_X;
    return s[AW-1:0];
  endfunction

  // Configuration registers
  logic [TIME_W-1:0] blk_limit, blk_rewind, window, still_time, sample_gap;
  logic [DIST_W-1:0] still_rad, still_dist;

  // Control and rewind state
  state_t            state;
  logic [AW-1:0]     head;
  logic [CNT_W-1:0]  cnt;
  logic              blk_run, chk_en, rw_active, started, dropped, fail;
  logic [TIME_W-1:0] blk_start, rw_start_ms, rw_dur;
  logic [DIST_W-1:0] rw_dist;
  pos_t              rw_start_pos;
  entry_t            newest, oldest;
  logic [CNT_W-1:0]  iss_idx, iss_left, rcv_left;
  logic              rd_vld;

  // Accepted word
  cmd_t              cmd_q;
  logic [TIME_W-1:0] t_q, dur_q;
  pos_t              pos_q;
  logic              flag_q;
  logic [DIST_W-1:0] dist_q;

  logic [R2_W-1:0]   r2, lim;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;
  dist_req_t         dreq;
  dist_rsp_t         drsp;

  logic              dur_keep, fail_now;
  logic [AW-1:0]     fix_head;
  logic [CNT_W-1:0]  fix_cnt;
  pos_t              start_pos;

  assign rd_entry      = entry_t'(ram_rdata);
  assign s_axis_tready = (state == ST_IDLE);
  assign dur_keep      = (rw_dur != '0) && tdiff_lt(t_q, rw_start_ms, rw_dur);
  assign start_pos     = (cnt != '0) ? newest.pos : '0;
  assign fail_now      = fail || ({2'b00, drsp.da} >= {6'd0, r2}) ||
                         ({2'b00, drsp.db} >= {6'd0, r2});

  always_comb begin
    fix_head = dropped ? ptr_dec(head) : head;
    fix_cnt  = cnt + CNT_W'(dropped);
    if ({1'b0, fix_cnt} >= DEPTH_X) begin
      fix_head = ptr_inc(fix_head);
      fix_cnt  = FULL_M1;
    end
  end

  // Memory port control
  assign ram_we    = (state == ST_ODO_WR);
  assign ram_waddr = ptr_add(head, cnt);
  assign ram_re    = (state == ST_ODO_ISS) || (state == ST_PS_OLD) ||
                     ((state == ST_PS_RUN) && (iss_left != '0));
  assign ram_raddr = (state == ST_PS_RUN) ? ptr_add(head, iss_idx) : head;

  // Streamed entries go against oldest and newest; otherwise the rewind start
  // is measured against the newest sample.
  always_comb begin
    dreq.valid = rd_vld || ((state == ST_EXEC) && (cmd_q == CMD_POLL) && rw_active &&
                            (rw_dist != '0) && (cnt != '0));
    dreq.p     = rd_vld ? rd_entry.pos : rw_start_pos;
    dreq.a     = rd_vld ? oldest.pos : newest.pos;
    dreq.b     = newest.pos;
  end

  sdrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({pos_q, t_q}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sdrm_dist u_dist (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    r2  <= still_rad * still_rad;
    lim <= rw_dist * rw_dist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_limit  <= RST_BLK_LIMIT;
      blk_rewind <= RST_BLK_REWIND;
      still_rad  <= RST_STILL_RAD;
      window     <= RST_WINDOW;
      still_dist <= RST_STILL_DIST;
      still_time <= RST_STILL_TIME;
      sample_gap <= RST_SAMPLE_GAP;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BLK_LIMIT:  blk_limit  <= cfg_data;
        REG_BLK_REWIND: blk_rewind <= cfg_data;
        REG_STILL_RAD:  still_rad  <= cfg_data[DIST_W-1:0];
        REG_WINDOW:     window     <= cfg_data;
        REG_STILL_DIST: still_dist <= cfg_data[DIST_W-1:0];
        REG_STILL_TIME: still_time <= cfg_data;
        REG_SAMPLE_GAP: sample_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      cnt           <= '0;
      blk_run       <= 1'b0;
      blk_start     <= '0;
      chk_en        <= 1'b1;
      rw_active     <= 1'b0;
      rw_start_ms   <= '0;
      rw_start_pos  <= '0;
      rw_dur        <= '0;
      rw_dist       <= '0;
      started       <= 1'b0;
      dropped       <= 1'b0;
      fail          <= 1'b0;
      rd_vld        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_vld <= (state == ST_PS_RUN) && (iss_left != '0);
      // In the final state the output register is reloaded instead.
      if (m_axis_tready && (state != ST_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q   <= cmd_t'(s_axis_tuser);
            t_q     <= s_axis_tdata[31:0];
            pos_q.x <= s_axis_tdata[55:32];
            pos_q.y <= s_axis_tdata[79:56];
            pos_q.z <= s_axis_tdata[103:80];
            flag_q  <= s_axis_tdata[104];
            dur_q   <= s_axis_tdata[136:105];
            dist_q  <= s_axis_tdata[160:137];
            started <= 1'b0;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (cmd_q)
            CMD_ODOM: begin
              dropped <= 1'b0;
              if ((cnt != '0) && tdiff_lt(t_q, newest.t, sample_gap)) begin
                state <= ST_FIN;
              end else if (cnt == '0) begin
                state <= ST_ODO_FIX;
              end else begin
                state <= ST_ODO_ISS;
              end
            end
            CMD_TRAJ: begin
              state <= ST_FIN;
              if (flag_q) begin
                blk_run <= 1'b0;
              end else if (!blk_run) begin
                blk_run   <= 1'b1;
                blk_start <= t_q;
              end
            end
            CMD_POLL: begin
              if (rw_active) begin
                if ((rw_dist != '0) && (cnt != '0)) begin
                  state <= ST_PA_WAIT;
                end else begin
                  state <= ST_FIN;
                  if (!dur_keep) begin
                    rw_active <= 1'b0;
                    if (rw_dist != '0) begin
                      cnt  <= '0;
                      head <= '0;
                    end else begin
                      blk_run <= 1'b0;
                    end
                  end
                end
              end else if (blk_run && tdiff_gt(t_q, blk_start, blk_limit)) begin
                rw_active    <= 1'b1;
                rw_start_ms  <= t_q;
                rw_start_pos <= start_pos;
                rw_dur       <= blk_rewind;
                rw_dist      <= '0;
                started      <= 1'b1;
                state        <= ST_FIN;
              end else if (chk_en && (cnt != '0)) begin
                state <= ST_PS_OLD;
              end else begin
                state <= ST_FIN;
              end
            end
            CMD_MANUAL: begin
              rw_active    <= 1'b1;
              rw_start_ms  <= t_q;
              rw_start_pos <= start_pos;
              rw_dur       <= dur_q;
              rw_dist      <= dist_q;
              started      <= 1'b1;
              state        <= ST_FIN;
            end
            CMD_CLEAR: begin
              cnt       <= '0;
              head      <= '0;
              rw_active <= 1'b0;
              blk_run   <= 1'b0;
              state     <= ST_FIN;
            end
            CMD_CHECK_EN: begin
              chk_en <= flag_q;
              state  <= ST_FIN;
            end
            default: state <= ST_FIN;
          endcase
        end
        ST_ODO_ISS: begin
          state <= ST_ODO_CMP;
        end
        ST_ODO_CMP: begin
          // Expired tail samples are dropped; the last one dropped comes back.
          if (tdiff_gt(t_q, rd_entry.t, window)) begin
            head    <= ptr_inc(head);
            cnt     <= cnt - 1'b1;
            dropped <= 1'b1;
            state   <= (cnt > CNT_W'(1)) ? ST_ODO_ISS : ST_ODO_FIX;
          end else begin
            state <= ST_ODO_FIX;
          end
        end
        ST_ODO_FIX: begin
          head  <= fix_head;
          cnt   <= fix_cnt;
          state <= ST_ODO_WR;
        end
        ST_ODO_WR: begin
          cnt    <= cnt + 1'b1;
          newest <= {pos_q, t_q};
          state  <= ST_FIN;
        end
        ST_PA_WAIT: begin
          if (drsp.valid) begin
            state <= ST_FIN;
            if (!(({2'b00, drsp.da} < {6'd0, lim}) && dur_keep)) begin
              rw_active <= 1'b0;
              cnt       <= '0;
              head      <= '0;
            end
          end
        end
        ST_PS_OLD: begin
          state <= ST_PS_OLDW;
        end
        ST_PS_OLDW: begin
          oldest <= rd_entry;
          state  <= ST_PS_CHK;
        end
        ST_PS_CHK: begin
          if (tdiff_lt(newest.t, oldest.t, window)) begin
            state <= ST_FIN;
          end else if (cnt <= CNT_W'(2)) begin
            rw_active    <= 1'b1;
            rw_start_ms  <= t_q;
            rw_start_pos <= newest.pos;
            rw_dur       <= still_time;
            rw_dist      <= still_dist;
            started      <= 1'b1;
            state        <= ST_FIN;
          end else begin
            iss_idx  <= CNT_W'(1);
            iss_left <= cnt - CNT_W'(2);
            rcv_left <= cnt - CNT_W'(2);
            fail     <= 1'b0;
            state    <= ST_PS_RUN;
          end
        end
        ST_PS_RUN: begin
          if (iss_left != '0) begin
            iss_idx  <= iss_idx + 1'b1;
            iss_left <= iss_left - 1'b1;
          end
          if (drsp.valid) begin
            rcv_left <= rcv_left - 1'b1;
            fail     <= fail_now;
            if (rcv_left == CNT_W'(1)) begin
              state <= ST_FIN;
              if (!fail_now) begin
                rw_active    <= 1'b1;
                rw_start_ms  <= t_q;
                rw_start_pos <= newest.pos;
                rw_dur       <= still_time;
                rw_dist      <= still_dist;
                started      <= 1'b1;
              end
            end
          end
        end
        ST_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= OUT_W'({cnt, blk_run, started, rw_active});
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SDRM_ASSERT_ALWAYS(a_cnt_bound, {1'b0, cnt} <= DEPTH_X)
  `SDRM_ASSERT_IMPLIES(a_start_active, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0])
  `SDRM_ASSERT_IMPLIES(a_ram_one_access, ram_we, !ram_re && !rd_vld)

endmodule
